[src/jfg_pkg.sv]
// jfg_pkg: shared types, constants and fixed-point helper functions of the
// jakes fading generator. Depends on nothing; every module but jfg_checker imports it.
package jfg_pkg;

    localparam int BASE_W = 44;
    localparam int SUM_W  = 48;
    localparam int GAIN_W = 18;
    localparam int FD_W   = 24;
    localparam int TIME_W = 32;
    localparam int TYPE_W = 2;
    localparam int OUT_DEPTH = 2;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [31:0] SQRT2_Q30 = 32'sd1518500250;
    localparam logic signed [63:0] GAIN_MAX = 64'sd131071;
    localparam logic signed [63:0] GAIN_MIN = -64'sd131072;
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 18'sd4096;

    // model variants
    localparam logic [TYPE_W-1:0] TYPE_ZERO = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_ONE  = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_TWO  = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_THREE = 2'd3;

    // configuration register indexes
    localparam logic CFG_DOPPLER = 1'b0;
    localparam logic CFG_TYPE    = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] si;
        logic signed [SUM_W-1:0] sq;
    } sum_t;

    // cosine of r/2^30 quarter cycles, Q16 result in [0, 65536]
    function automatic logic signed [63:0] cos_quarter(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic signed [63:0] c;
        x   = (r * HALF_PI_Q30) >> 30;
        x2  = (x * x) >> 30;
        acc = Q30_ONE - x2 / 64'd132;
        acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd90;
        acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd56;
        acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd30;
        acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd12;
        c   = $signed(Q30_ONE) - $signed(((x2 * acc) >> 30) / 64'd2);
        if (c < 0)
            c = 0;
        return (c + 64'sd8192) >>> 14;
    endfunction

    // cosine of a Q0.32 cycle fraction
    function automatic logic signed [63:0] cos_cycle(input logic [31:0] p);
        logic [63:0] r;
        logic signed [63:0] v;
        r = {34'd0, p[29:0]};
        case (p[31:30])
            2'd0:    v = cos_quarter(r);
            2'd1:    v = -cos_quarter(Q30_ONE - r);
            2'd2:    v = -cos_quarter(r);
            default: v = cos_quarter(Q30_ONE - r);
        endcase
        return v;
    endfunction

    // nearest table entry of a phase, wrapped to the table size
    function automatic logic [63:0] tab_index(input logic [31:0] p, input logic [63:0] d);
        logic [63:0] j;
        j = ({32'd0, p} * d + 64'h8000_0000) >> 32;
        if (j >= d)
            j = 64'd0;
        return j;
    endfunction

    // integer square root
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // arithmetic right shift, rounding half away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

endpackage

[src/jfg_front.sv]
// jfg_front: input request acceptance, time-by-doppler product and a two
// entry queue toward the oscillator engine. Depends on jfg_pkg.
module jfg_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [jfg_pkg::TIME_W-1:0]  sample_time,
    input  logic [jfg_pkg::FD_W-1:0]    doppler_freq,
    output logic                        q_valid,
    output logic [jfg_pkg::BASE_W-1:0]  q_base,
    input  logic                        q_ready
);
    import jfg_pkg::*;

    logic [BASE_W-1:0] slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [FD_W+TIME_W-1:0] prod;
    logic              push;
    logic              pop;

    // doppler times time; only the low bits matter for the phase
    assign prod = {{TIME_W{1'b0}}, doppler_freq} * {{FD_W{1'b0}}, sample_time};

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_base   = slot_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= prod[BASE_W-1:0];
    end

endmodule

[src/jfg_osc.sv]
// jfg_osc: oscillator engine, one term per cycle while a request is in progress,
// through a shared pipeline of phase product, table index, cosine rom, weighting
// and accumulation. Depends on jfg_pkg.
module jfg_osc #(
    parameter int NUM_OSC = 32,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [jfg_pkg::TYPE_W-1:0]  model_type,
    input  logic                        q_valid,
    input  logic [jfg_pkg::BASE_W-1:0]  q_base,
    output logic                        q_ready,
    input  logic                        credit_ret,
    output jfg_pkg::sum_t               sum_o
);
    import jfg_pkg::*;

    localparam int KW = $clog2(NUM_OSC + 1);
    localparam int IW = $clog2(COS_TABLE_DEPTH);
    localparam logic [KW-1:0] K_LAST = KW'(NUM_OSC);
    localparam logic [63:0] D64      = 64'(COS_TABLE_DEPTH);
    localparam logic [63:0] OSC_DIV  = 64'(4 * NUM_OSC + 2);
    localparam logic [63:0] BETA1    = 64'(2 * NUM_OSC + 2);
    localparam logic [63:0] BETA2    = 64'(2 * NUM_OSC);

    // constant tables
    logic signed [17:0] ck_tab  [NUM_OSC+1];
    logic signed [17:0] cb1_tab [NUM_OSC+1];
    logic signed [17:0] sb1_tab [NUM_OSC+1];
    logic signed [17:0] cb2_tab [NUM_OSC+1];
    logic signed [17:0] sb2_tab [NUM_OSC+1];
    logic signed [17:0] rom_tab [COS_TABLE_DEPTH];

    for (genvar gk = 0; gk <= NUM_OSC; gk++)
    begin : g_coef
        localparam logic [63:0] PC  = (64'(gk) << 32) / OSC_DIV;
        localparam logic [63:0] EC  = (tab_index(PC[31:0], D64) << 32) / D64;
        localparam logic [63:0] PB1 = (64'(gk) << 32) / BETA1;
        localparam logic [63:0] PB2 = (64'(gk) << 32) / BETA2;
        localparam logic [31:0] PS1 = PB1[31:0] - 32'h4000_0000;
        localparam logic [31:0] PS2 = PB2[31:0] - 32'h4000_0000;
        localparam logic [63:0] EB1 = (tab_index(PB1[31:0], D64) << 32) / D64;
        localparam logic [63:0] ES1 = (tab_index(PS1, D64) << 32) / D64;
        localparam logic [63:0] EB2 = (tab_index(PB2[31:0], D64) << 32) / D64;
        localparam logic [63:0] ES2 = (tab_index(PS2, D64) << 32) / D64;
        localparam logic signed [63:0] CKV = (gk == 0) ? 64'sd65536 : cos_cycle(EC[31:0]);
        assign ck_tab[gk]  = 18'(CKV);
        assign cb1_tab[gk] = 18'(cos_cycle(EB1[31:0]));
        assign sb1_tab[gk] = 18'(cos_cycle(ES1[31:0]));
        assign cb2_tab[gk] = 18'(cos_cycle(EB2[31:0]));
        assign sb2_tab[gk] = 18'(cos_cycle(ES2[31:0]));
    end

    for (genvar gj = 0; gj < COS_TABLE_DEPTH; gj++)
    begin : g_rom
        localparam logic [63:0] EJ = (64'(gj) << 32) / D64;
        assign rom_tab[gj] = 18'(cos_cycle(EJ[31:0]));
    end

    // sequencer state
    logic              busy_reg, busy_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              last_issue;
    logic              start;

    assign last_issue = busy_reg && (k_reg == K_LAST);
    assign start      = q_valid && (!busy_reg || last_issue) && (cnt_reg != 2'(OUT_DEPTH));
    assign q_ready    = start;

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        base_next = base_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            base_next = q_base;
        end
        else if (last_issue)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            k_next = k_reg + 1'b1;
        end
        cnt_next = cnt_reg + {1'b0, start} - {1'b0, credit_ret};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
    end

    // pipeline tags
    logic          s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic          s1_f_reg, s2_f_reg, s3_f_reg, s4_f_reg;
    logic          s1_l_reg, s2_l_reg, s3_l_reg, s4_l_reg;
    logic [KW-1:0] s1_k_reg, s2_k_reg, s3_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= busy_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_f_reg <= (k_reg == '0);
        s1_l_reg <= (k_reg == K_LAST);
        s1_k_reg <= k_reg;
        s2_f_reg <= s1_f_reg;
        s2_l_reg <= s1_l_reg;
        s2_k_reg <= s1_k_reg;
        s3_f_reg <= s2_f_reg;
        s3_l_reg <= s2_l_reg;
        s3_k_reg <= s2_k_reg;
        s4_f_reg <= s3_f_reg;
        s4_l_reg <= s3_l_reg;
    end

    // stage 1: oscillator phase, Q0.32
    logic [60:0] ph_prod;
    logic [31:0] s1_phase_reg;
    assign ph_prod = {17'd0, base_reg} * {44'd0, ck_tab[k_reg][16:0]};

    always_ff @(posedge clk)
    begin
        s1_phase_reg <= ph_prod[43:12];
    end

    // stage 2: nearest table index
    logic [63:0]   j_full;
    logic [IW-1:0] s2_idx_reg;
    assign j_full = ({32'd0, s1_phase_reg} * D64 + 64'h8000_0000) >> 32;

    always_ff @(posedge clk)
    begin
        s2_idx_reg <= (j_full >= D64) ? '0 : j_full[IW-1:0];
    end

    // stage 3: cosine rom read
    logic signed [17:0] s3_cw_reg;
    always_ff @(posedge clk)
    begin
        s3_cw_reg <= rom_tab[s2_idx_reg];
    end

    // stage 4: branch weighting
    logic [TYPE_W-1:0]       kind;
    logic signed [17:0]      cb;
    logic signed [17:0]      sb;
    logic signed [63:0]      main_sq2;
    logic signed [35:0]      wi;
    logic signed [35:0]      wq;
    logic signed [SUM_W-1:0] ti;
    logic signed [SUM_W-1:0] tq;
    logic signed [SUM_W-1:0] s4_ti_reg;
    logic signed [SUM_W-1:0] s4_tq_reg;

    assign kind = (model_type == TYPE_ZERO) ? TYPE_ONE : model_type;

    always_comb
    begin
        cb       = (kind == TYPE_ONE) ? cb1_tab[s3_k_reg] : cb2_tab[s3_k_reg];
        sb       = (kind == TYPE_ONE) ? sb1_tab[s3_k_reg] : sb2_tab[s3_k_reg];
        main_sq2 = rnd_shift(64'(SQRT2_Q30) * 64'(s3_cw_reg), 14);
        wi       = 36'(cb) * 36'(s3_cw_reg);
        wq       = 36'(sb) * 36'(s3_cw_reg);
        if (s3_k_reg == '0)
        begin
            if (kind == TYPE_THREE)
            begin
                ti = SUM_W'(s3_cw_reg) <<< 16;
                tq = SUM_W'(s3_cw_reg) <<< 16;
            end
            else
            begin
                ti = SUM_W'(main_sq2);
                tq = '0;
            end
        end
        else
        begin
            ti = SUM_W'(wi) <<< 1;
            tq = SUM_W'(wq) <<< 1;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_ti_reg <= ti;
        s4_tq_reg <= tq;
    end

    // stage 5: accumulation per request
    logic signed [SUM_W-1:0] acc_i_reg, acc_i_next;
    logic signed [SUM_W-1:0] acc_q_reg, acc_q_next;
    logic                    sum_v_reg;
    logic signed [SUM_W-1:0] sum_i_reg;
    logic signed [SUM_W-1:0] sum_q_reg;

    assign acc_i_next = (s4_f_reg ? '0 : acc_i_reg) + s4_ti_reg;
    assign acc_q_next = (s4_f_reg ? '0 : acc_q_reg) + s4_tq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_v_reg <= 1'b0;
        else
            sum_v_reg <= s4_v_reg && s4_l_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s4_v_reg)
        begin
            acc_i_reg <= acc_i_next;
            acc_q_reg <= acc_q_next;
        end
        if (s4_v_reg && s4_l_reg)
        begin
            sum_i_reg <= acc_i_next;
            sum_q_reg <= acc_q_next;
        end
    end

    assign sum_o.valid = sum_v_reg;
    assign sum_o.si    = sum_i_reg;
    assign sum_o.sq    = sum_q_reg;

endmodule

[src/jfg_norm.sv]
// jfg_norm: branch normalisation, rounding, saturation and the result queue
// toward the output port. Depends on jfg_pkg.
module jfg_norm #(
    parameter int NUM_OSC = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [jfg_pkg::TYPE_W-1:0]        model_type,
    input  logic                              fd_zero,
    input  jfg_pkg::sum_t                     sum_i,
    output logic                              credit_ret,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [jfg_pkg::GAIN_W-1:0] fade_inphase,
    output logic signed [jfg_pkg::GAIN_W-1:0] fade_quadrature
);
    import jfg_pkg::*;

    localparam logic [63:0] G_A = isqrt64((64'd1 << 60) / 64'(2 * NUM_OSC));
    localparam logic [63:0] G_B = isqrt64((64'd1 << 60) / 64'(2 * NUM_OSC + 2));
    localparam logic [63:0] G_C = isqrt64((64'd1 << 60) / 64'(2 * NUM_OSC + 1));

    logic [TYPE_W-1:0] kind;
    logic [29:0]       gi;
    logic [29:0]       gq;

    assign kind = (model_type == TYPE_ZERO) ? TYPE_ONE : model_type;

    // normaliser per branch
    always_comb
    begin
        case (kind)
            TYPE_ONE:
            begin
                gi = G_A[29:0];
                gq = G_B[29:0];
            end
            TYPE_TWO:
            begin
                gi = G_B[29:0];
                gq = G_A[29:0];
            end
            default:
            begin
                gi = G_C[29:0];
                gq = G_C[29:0];
            end
        endcase
    end

    // stage 1: round the sums to Q24
    logic               n1_v_reg;
    logic signed [33:0] n1_i_reg;
    logic signed [33:0] n1_q_reg;
    logic [29:0]        n1_gi_reg;
    logic [29:0]        n1_gq_reg;

    // stage 2: scale
    logic               n2_v_reg;
    logic signed [63:0] n2_i_reg;
    logic signed [63:0] n2_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_v_reg <= 1'b0;
            n2_v_reg <= 1'b0;
        end
        else
        begin
            n1_v_reg <= sum_i.valid;
            n2_v_reg <= n1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_i_reg  <= 34'(rnd_shift(64'(sum_i.si), 8));
        n1_q_reg  <= 34'(rnd_shift(64'(sum_i.sq), 8));
        n1_gi_reg <= gi;
        n1_gq_reg <= gq;
        n2_i_reg  <= 64'(n1_i_reg) * $signed({34'd0, n1_gi_reg});
        n2_q_reg  <= 64'(n1_q_reg) * $signed({34'd0, n1_gq_reg});
    end

    // stage 3: round to Q5.12 and saturate
    logic signed [63:0]       ri;
    logic signed [63:0]       rq;
    logic signed [GAIN_W-1:0] vi;
    logic signed [GAIN_W-1:0] vq;

    always_comb
    begin
        ri = rnd_shift(n2_i_reg, 42);
        rq = rnd_shift(n2_q_reg, 42);
        if (ri > GAIN_MAX)
            vi = GAIN_W'(GAIN_MAX);
        else if (ri < GAIN_MIN)
            vi = GAIN_W'(GAIN_MIN);
        else
            vi = GAIN_W'(ri);
        if (rq > GAIN_MAX)
            vq = GAIN_W'(GAIN_MAX);
        else if (rq < GAIN_MIN)
            vq = GAIN_W'(GAIN_MIN);
        else
            vq = GAIN_W'(rq);
        if (fd_zero)
        begin
            vi = GAIN_ONE;
            vq = '0;
        end
    end

    // result queue
    logic signed [GAIN_W-1:0] qi_reg [OUT_DEPTH];
    logic signed [GAIN_W-1:0] qq_reg [OUT_DEPTH];
    logic                     wr_ptr_reg, wr_ptr_next;
    logic                     rd_ptr_reg, rd_ptr_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic                     pop;

    assign out_valid       = (cnt_reg != 2'd0);
    assign pop             = out_valid && out_ready;
    assign credit_ret      = pop;
    assign fade_inphase    = qi_reg[rd_ptr_reg];
    assign fade_quadrature = qq_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = n2_v_reg ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, n2_v_reg} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n2_v_reg)
        begin
            qi_reg[wr_ptr_reg] <= vi;
            qq_reg[wr_ptr_reg] <= vq;
        end
    end

endmodule

[src/jakes_fading_generator_top.sv]
// jakes_fading_generator_top: jakes sum-of-sinusoids fading generator.
// Depends on jfg_pkg, jfg_front, jfg_osc and jfg_norm.
//
// Usage:
//   Input channel in_valid/in_ready carries one sample_time (unsigned Q16.16)
//   per request. Output channel out_valid/out_ready carries fade_inphase and
//   fade_quadrature (signed Q5.12, saturated) for that request, in order.
//   Configuration: cfg_we with cfg_index 0 writes doppler_freq (Q12.12 Hz),
//   index 1 writes model_type; write only while no request is in flight.
// Timing:
//   The oscillator engine works through NUM_OSC+1 oscillator terms per request,
//   one oscillator term per cycle through its shared pipeline, and can start
//   the next request as it issues the last term, while a result credit is free.
//   A request passes the input queue, engine pipeline, normaliser and result queue.
// Reset and stall:
//   Reset empties all queues; doppler_freq resets to 0 and model_type to 2.
//   A stalled receiver fills the two-entry result queue; the engine then
//   stops starting requests and the two-entry input queue fills before
//   in_ready drops.
module jakes_fading_generator_top #(
    parameter int NUM_OSC = 32,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [jfg_pkg::FD_W-1:0]          cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [jfg_pkg::TIME_W-1:0]        sample_time,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [jfg_pkg::GAIN_W-1:0] fade_inphase,
    output logic signed [jfg_pkg::GAIN_W-1:0] fade_quadrature
);
    import jfg_pkg::*;

    logic [FD_W-1:0]   doppler_freq_reg;
    logic [TYPE_W-1:0] model_type_reg;
    logic              q_valid;
    logic [BASE_W-1:0] q_base;
    logic              q_ready;
    logic              credit_ret;
    sum_t              sum_w;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            doppler_freq_reg <= '0;
            model_type_reg   <= TYPE_TWO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DOPPLER: doppler_freq_reg <= cfg_data;
                CFG_TYPE:    model_type_reg   <= cfg_data[TYPE_W-1:0];
                default:     model_type_reg   <= model_type_reg;
            endcase
        end
    end

    jfg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_time  (sample_time),
        .doppler_freq (doppler_freq_reg),
        .q_valid      (q_valid),
        .q_base       (q_base),
        .q_ready      (q_ready)
    );

    jfg_osc #(
        .NUM_OSC         (NUM_OSC),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_osc (
        .clk        (clk),
        .rst_n      (rst_n),
        .model_type (model_type_reg),
        .q_valid    (q_valid),
        .q_base     (q_base),
        .q_ready    (q_ready),
        .credit_ret (credit_ret),
        .sum_o      (sum_w)
    );

    jfg_norm #(
        .NUM_OSC (NUM_OSC)
    ) u_norm (
        .clk             (clk),
        .rst_n           (rst_n),
        .model_type      (model_type_reg),
        .fd_zero         (doppler_freq_reg == '0),
        .sum_i           (sum_w),
        .credit_ret      (credit_ret),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fade_inphase    (fade_inphase),
        .fade_quadrature (fade_quadrature)
    );

endmodule

[src/jfg_checker.sv]
// jfg_checker: port-level checks of the fading generator, bound to the top.
// Depends on jakes_fading_generator_top ports only.
module jfg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [17:0] fade_inphase,
    input logic [17:0] fade_quadrature
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(fade_inphase) && $stable(fade_quadrature))
        else $error("result payload changed while stalled");

    // reset leaves no result and an open input
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("queues not empty after reset");

endmodule

bind jakes_fading_generator_top jfg_checker u_jfg_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .fade_inphase    (fade_inphase),
    .fade_quadrature (fade_quadrature)
);
